>>> rtl/core/olst_pkg.sv
// Shared types and constants for the ordered list store.
// Used by the channel interfaces, the cell, the controller and the top level.
// No dependencies.
`default_nettype none

package olst_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TOTAL_W = 9;

  localparam logic [DATA_W-1:0] READ_PAST_END = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND   = 3'd0,
    MODE_POP      = 3'd1,
    MODE_RM_FIRST = 3'd2,
    MODE_RM_ALL   = 3'd3,
    MODE_SEARCH   = 3'd4,
    MODE_READ     = 3'd5
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic              shift;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/olst_cmd_if.sv
// Command channel of the ordered list store: valid/ready plus command fields.
// Depends on olst_pkg for the field widths.
`default_nettype none

interface olst_cmd_if;
  import olst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

`default_nettype wire

>>> rtl/core/olst_rsp_if.sv
// Result channel of the ordered list store: valid/ready plus result fields.
// Depends on olst_pkg for the field widths.
`default_nettype none

interface olst_rsp_if;
  import olst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     found;
  logic signed [DATA_W-1:0] read_value;
  logic [TOTAL_W-1:0]       element_total;

  modport source (output valid, output status, output found, output read_value,
                  output element_total, input ready);
  modport sink   (input valid, input status, input found, input read_value,
                  input element_total, output ready);
endinterface

`default_nettype wire

>>> rtl/core/olst_cell.sv
// One storage cell of the list chain: loads from the write bus or its right neighbor.
// Depends on olst_pkg for the cell control struct.
`default_nettype none

module olst_cell (
  input  wire logic                         clk_i,
  input  wire olst_pkg::cell_ctl_t          ctl_i,
  input  wire logic                         sel_i,
  input  wire logic [olst_pkg::DATA_W-1:0]  next_i,
  output logic      [olst_pkg::DATA_W-1:0]  data_o
);
  import olst_pkg::*;

  logic [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && sel_i) begin
      data_q <= ctl_i.wr_data;
    end else if (ctl_i.shift) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> rtl/core/olst_ctrl.sv
// Command sequencer of the ordered list store: element count, scan walk, result register.
// Depends on olst_pkg and the olst_cmd_if / olst_rsp_if channels.
`default_nettype none

module olst_ctrl #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  olst_cmd_if.sink                                   cmd_i,
  olst_rsp_if.source                                 rsp_o,
  input  wire logic [olst_pkg::DATA_W-1:0]           head_i,
  output olst_pkg::cell_ctl_t                        cell_ctl_o,
  output logic [$clog2(CAPACITY)-1:0]                wr_idx_o
);
  import olst_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e             state_q;
  mode_e              mode_q;
  logic [DATA_W-1:0]  value_q;
  logic [POS_W-1:0]   pos_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      n_q;
  logic [CW-1:0]      k_q;
  logic               found_q;
  logic [DATA_W-1:0]  rd_q;
  status_e            status_q;

  logic               rsp_valid_q;
  status_e            rsp_status_q;
  logic               rsp_found_q;
  logic [DATA_W-1:0]  rsp_rd_q;
  logic [TOTAL_W-1:0] rsp_total_q;

  logic          accept;
  mode_e         cmd_mode;
  logic          match;
  logic          drop;
  logic          full;
  logic          pos_in_range;
  logic          load_rsp;
  logic [CW-1:0] cnt_m1;

  assign cmd_i.ready  = (state_q == S_IDLE);
  assign accept       = cmd_i.valid && cmd_i.ready;
  assign cmd_mode     = mode_e'(cmd_i.mode);
  assign match        = (head_i == value_q);
  assign full         = (cnt_q >= CW'(CAPACITY));
  assign cnt_m1       = cnt_q - CW'(1);
  assign pos_in_range = (PW'(cmd_i.position) < PW'(cnt_q));
  assign load_rsp     = (state_q == S_FINISH) && (!rsp_valid_q || rsp_o.ready);
  assign drop         = (state_q == S_SCAN) && match &&
                        ((mode_q == MODE_RM_ALL) || ((mode_q == MODE_RM_FIRST) && !found_q));

  always_comb begin
    cell_ctl_o.shift   = (state_q == S_SCAN);
    cell_ctl_o.wr_en   = 1'b0;
    cell_ctl_o.wr_data = head_i;
    wr_idx_o           = cnt_m1[AW-1:0];
    if (state_q == S_SCAN) begin
      cell_ctl_o.wr_en = !drop;
    end else if (accept && (cmd_mode == MODE_APPEND) && !full) begin
      cell_ctl_o.wr_en   = 1'b1;
      cell_ctl_o.wr_data = cmd_i.value;
      wr_idx_o           = cnt_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q   <= cmd_mode;
            value_q  <= cmd_i.value;
            pos_q    <= cmd_i.position;
            n_q      <= cnt_q;
            k_q      <= '0;
            found_q  <= 1'b0;
            rd_q     <= '0;
            status_q <= ST_OK;
            state_q  <= S_FINISH;
            if (cmd_mode == MODE_APPEND) begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                cnt_q <= cnt_q + CW'(1);
              end
            end else if (cnt_q == '0) begin
              unique case (cmd_mode)
                MODE_POP, MODE_RM_FIRST, MODE_RM_ALL, MODE_SEARCH, MODE_READ: begin
                  status_q <= ST_EMPTY;
                end
                default: begin
                end
              endcase
            end else begin
              unique case (cmd_mode)
                MODE_POP: begin
                  cnt_q <= cnt_m1;
                end
                MODE_RM_FIRST, MODE_RM_ALL, MODE_SEARCH: begin
                  state_q <= S_SCAN;
                end
                MODE_READ: begin
                  if (pos_in_range) begin
                    state_q <= S_SCAN;
                  end else begin
                    rd_q <= READ_PAST_END;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_SCAN: begin
          k_q <= k_q + CW'(1);
          if (drop) begin
            cnt_q <= cnt_m1;
          end
          if (match && (mode_q != MODE_READ)) begin
            found_q <= 1'b1;
          end
          if ((mode_q == MODE_READ) && (PW'(k_q) == PW'(pos_q))) begin
            rd_q <= head_i;
          end
          if (k_q == n_q - CW'(1)) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_rsp) begin
            rsp_status_q <= status_q;
            rsp_found_q  <= found_q;
            rsp_rd_q     <= rd_q;
            rsp_total_q  <= TOTAL_W'(cnt_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.found         = rsp_found_q;
  assign rsp_o.read_value    = rsp_rd_q;
  assign rsp_o.element_total = rsp_total_q;

  // The count never passes the capacity of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  // A scan never lengthens the list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> (cnt_q <= $past(cnt_q)))
    else $error("element count grew during a scan");

  // A scan never removes more elements than it has walked over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (n_q - cnt_q <= k_q))
    else $error("more elements removed than scanned");

  // A new result is loaded only when leaving the finish step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == S_FINISH))
    else $error("result valid raised outside the finish step");

  // An accepted transaction always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted transaction left the sequencer idle");

endmodule

`default_nettype wire

>>> rtl/core/ordered_list_store_top.sv
// Ordered list store: a chain of CAPACITY cells holding the list packed from cell 0.
// Append, pop, past-end read, no-op and empty-list commands go from acceptance to the finish step
// and then to the result register. Search, removals and in-range reads rotate the list once
// through cell 0 first. One command at a time; a result not yet taken holds the next command
// in its finish step, and no further command is accepted until that result is taken.
// Reset clears the count and the result channel; cell contents are not reset.
// Depends on olst_pkg, olst_cmd_if, olst_rsp_if, olst_cell and olst_ctrl.
`default_nettype none

module ordered_list_store_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  olst_cmd_if.sink   cmd_i,
  olst_rsp_if.source rsp_o
);
  import olst_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  cell_ctl_t         cell_ctl;
  logic [AW-1:0]     wr_idx;
  logic [DATA_W-1:0] cell_data [CAPACITY];

  olst_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .rsp_o      (rsp_o),
    .head_i     (cell_data[0]),
    .cell_ctl_o (cell_ctl),
    .wr_idx_o   (wr_idx)
  );

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [DATA_W-1:0] next_data;
    if (gi == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[gi];
    end else begin : g_mid
      assign next_data = cell_data[gi+1];
    end

    olst_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .sel_i  (wr_idx == AW'(gi)),
      .next_i (next_data),
      .data_o (cell_data[gi])
    );
  end

endmodule

`default_nettype wire

>>> tb/ordered_list_store_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_store_top. It keeps a mirror of the list
// and checks every result transaction. It depends on olst_pkg, olst_cmd_if, olst_rsp_if
// and the RTL of the block.

typedef struct packed {
  olst_pkg::status_e  status;
  logic               found;
  logic [31:0]        read_value;
  logic [8:0]         total;
} list_reply_t;

class list_mirror;
  int unsigned capacity;
  logic [31:0] entries[$];
  list_reply_t pending_replies[$];
  int unsigned errors;
  int unsigned commands;
  int unsigned checked;
  int unsigned full_drops;
  int unsigned empty_hits;
  int unsigned match_hits;
  int unsigned past_end_reads;
  int unsigned longest;

  function new(int unsigned cap);
    capacity = cap;
  endfunction

  function void note_command(logic [2:0] mode, logic [31:0] value, logic [7:0] position);
    list_reply_t reply;
    logic [31:0] kept[$];
    int i;
    reply.status = olst_pkg::ST_OK;
    reply.found = 1'b0;
    reply.read_value = '0;
    commands++;
    if (mode == olst_pkg::MODE_APPEND) begin
      if (entries.size() >= capacity) begin
        reply.status = olst_pkg::ST_FULL;
        full_drops++;
      end else begin
        entries.push_back(value);
      end
    end else if (mode > olst_pkg::MODE_READ) begin
      reply.status = olst_pkg::ST_OK;
    end else if (entries.size() == 0) begin
      reply.status = olst_pkg::ST_EMPTY;
      empty_hits++;
    end else begin
      case (mode)
        olst_pkg::MODE_POP: begin
          void'(entries.pop_back());
        end
        olst_pkg::MODE_RM_FIRST: begin
          for (i = 0; i < entries.size(); i++) begin
            if (entries[i] == value) begin
              entries.delete(i);
              reply.found = 1'b1;
              break;
            end
          end
        end
        olst_pkg::MODE_RM_ALL: begin
          for (i = 0; i < entries.size(); i++) begin
            if (entries[i] == value) reply.found = 1'b1;
            else kept.push_back(entries[i]);
          end
          entries = kept;
        end
        olst_pkg::MODE_SEARCH: begin
          for (i = 0; i < entries.size(); i++) begin
            if (entries[i] == value) begin
              reply.found = 1'b1;
              break;
            end
          end
        end
        default: begin
          if (position < entries.size()) begin
            reply.read_value = entries[position];
          end else begin
            reply.read_value = olst_pkg::READ_PAST_END;
            past_end_reads++;
          end
        end
      endcase
    end
    if (reply.found) match_hits++;
    if (entries.size() > longest) longest = entries.size();
    reply.total = 9'(entries.size());
    pending_replies.push_back(reply);
  endfunction

  function void check_result(logic [1:0] status, logic found, logic [31:0] read_value,
                             logic [8:0] total);
    list_reply_t want;
    if (pending_replies.size() == 0) begin
      $error("Result transaction arrived with no command outstanding.");
      errors++;
      return;
    end
    want = pending_replies.pop_front();
    checked++;
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      errors++;
    end
    if (found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, found);
      errors++;
    end
    if (read_value !== want.read_value) begin
      $error("read_value: expected %0d, got %0d", $signed(want.read_value), $signed(read_value));
      errors++;
    end
    if (total !== want.total) begin
      $error("element_total: expected %0d, got %0d", want.total, total);
      errors++;
    end
  endfunction
endclass

module ordered_list_store_top_tb;
  import olst_pkg::*;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
  localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic quiet;
  int unsigned cycle_count;
  logic [DATA_W-1:0] value_pool[16];

  list_mirror book = new(CAPACITY);

  olst_cmd_if cmd_if ();
  olst_rsp_if rsp_if ();

  ordered_list_store_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if.sink),
    .rsp_o (rsp_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!quiet) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      book.check_result(rsp_if.status, rsp_if.found, rsp_if.read_value, rsp_if.element_total);
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 15)];
    return $urandom();
  endfunction

  task automatic send_command(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value,
                              logic [POS_W-1:0] position);
    cmd_if.valid <= 1'b1;
    cmd_if.mode <= mode;
    cmd_if.value <= value;
    cmd_if.position <= position;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    book.note_command(mode, value, position);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int unsigned append_pct);
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0] position;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < append_pct) begin
      mode = MODE_APPEND;
    end else begin
      roll = $urandom_range(0, 40);
      if (roll < 10) mode = MODE_POP;
      else if (roll < 18) mode = MODE_RM_FIRST;
      else if (roll < 23) mode = MODE_RM_ALL;
      else if (roll < 31) mode = MODE_SEARCH;
      else if (roll < 39) mode = MODE_READ;
      else mode = roll[0] ? MODE_SPARE_A : MODE_SPARE_B;
    end
    if ($urandom_range(0, 1) == 1 && book.entries.size() > 0) begin
      position = POS_W'($urandom_range(0, book.entries.size() - 1));
    end else begin
      position = POS_W'($urandom_range(0, 255));
    end
    send_command(mode, pick_value(), position);
  endtask

  task automatic wait_for_replies();
    cmd_if.valid <= 1'b0;
    while (book.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    quiet = 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.mode <= MODE_APPEND;
    cmd_if.value <= '0;
    cmd_if.position <= '0;
    value_pool[0] = MOST_NEGATIVE;
    value_pool[1] = MOST_POSITIVE;
    value_pool[2] = '0;
    value_pool[3] = '1;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every command on an empty list, then a short list with duplicates.
    send_command(MODE_POP, $urandom(), '0);
    send_command(MODE_SEARCH, MOST_POSITIVE, '0);
    send_command(MODE_RM_FIRST, '0, '0);
    send_command(MODE_RM_ALL, '1, '0);
    send_command(MODE_READ, $urandom(), 8'hFF);
    send_command(MODE_SPARE_A, $urandom(), POS_W'($urandom()));
    send_command(MODE_APPEND, MOST_NEGATIVE, '0);
    send_command(MODE_APPEND, MOST_POSITIVE, '0);
    send_command(MODE_APPEND, '0, '0);
    send_command(MODE_APPEND, MOST_POSITIVE, '0);
    send_command(MODE_APPEND, '1, '0);
    send_command(MODE_READ, '0, 8'd0);
    send_command(MODE_READ, '0, 8'd4);
    send_command(MODE_READ, '0, 8'd5);
    send_command(MODE_READ, '0, 8'hFF);
    send_command(MODE_SEARCH, MOST_POSITIVE, '0);
    send_command(MODE_SEARCH, 32'd5, '0);
    send_command(MODE_RM_ALL, MOST_POSITIVE, '0);
    send_command(MODE_RM_FIRST, '1, '0);
    send_command(MODE_APPEND, 32'd9, '0);
    send_command(MODE_READ, '0, 8'd2);
    send_command(MODE_RM_FIRST, 32'd12345, '0);
    send_command(MODE_RM_ALL, 32'd77, '0);
    send_command(MODE_POP, '0, '0);
    send_command(MODE_SPARE_B, $urandom(), POS_W'($urandom()));

    repeat (280) send_random(60);

    // Fill the list to capacity, then push against the full condition.
    while (book.entries.size() < CAPACITY) begin
      if ($urandom_range(0, 7) == 0) send_random(0);
      else send_command(MODE_APPEND, pick_value(), POS_W'($urandom()));
    end
    repeat (6) send_command(MODE_APPEND, $urandom(), POS_W'($urandom()));
    send_command(MODE_READ, '0, 8'hFF);
    send_command(MODE_SEARCH, $urandom(), '0);
    send_command(MODE_POP, '0, '0);
    send_command(MODE_APPEND, MOST_NEGATIVE, '0);
    send_command(MODE_APPEND, MOST_POSITIVE, '0);

    repeat (130) send_random(40);
    quiet = 1'b1;
    repeat (130) send_random(40);
    quiet = 1'b0;

    wait_for_replies();

    while (book.entries.size() > 0) send_random(5);
    repeat (6) send_random(0);

    quiet = 1'b1;
    repeat (150) send_random(50);

    wait_for_replies();
    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("Checked %0d results for %0d commands; the list grew to %0d entries.",
             book.checked, book.commands, book.longest);
    $display("Seen: %0d full drops, %0d empty-list results, %0d matches, %0d past-end reads.",
             book.full_drops, book.empty_hits, book.match_hits, book.past_end_reads);
    if (book.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/olst_pkg.sv
rtl/core/olst_cmd_if.sv
rtl/core/olst_rsp_if.sv
rtl/core/olst_cell.sv
rtl/core/olst_ctrl.sv
rtl/core/ordered_list_store_top.sv
tb/ordered_list_store_top_tb.sv
